### sv/gwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher package
// Shared constants, request kinds, the per-cell control bundle and the
// ASCII case folding helper.
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_VALUE  = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic       update;   // active set takes its next value
        logic       advance;  // next value comes from a value byte, else restart
        logic       fold_en;  // ASCII case-insensitive literal compare
        logic [7:0] ch;       // value byte or pattern byte being written
    } t_cell_ctl;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage

### sv/gwm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher input channel
// Carries one request: its kind and a pattern or value byte.
// ----------------------------------------------------------------------------
interface gwm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] ch;

    modport source (output valid, output kind, output ch, input ready);
    modport sink   (input valid, input kind, input ch, output ready);
endinterface

### sv/gwm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher result channel
// Carries the match verdict and the pattern overflow flag.
// ----------------------------------------------------------------------------
interface gwm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

### sv/gwm_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher configuration channel
// Writes the single case-insensitive control bit.
// ----------------------------------------------------------------------------
interface gwm_cfg_if;
    logic valid;
    logic ready;
    logic case_insensitive;

    modport source (output valid, output case_insensitive, input ready);
    modport sink   (input valid, input case_insensitive, output ready);
endinterface

### sv/glob_wildcard_matcher_unit.sv
// An end-of-value request shows its result on the output in the cycle after acceptance.
// Throughput: one request per cycle; the input stalls only while an unclaimed result waits
// and the sink holds off, since the output register is the only buffer.
// Every request updates the whole row of position cells in the cycle it is accepted.
// Reset (synchronous, active low) empties the pattern, clears overflow, the case bit and
// the output valid flag; the pattern bytes and result payload are undefined until written.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher
// Streaming glob matcher built from a row of position cells: '*' matches any
// run, '?' one byte, anything else itself; the verdict comes on end of value.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    gwm_in_if.sink    i_in,
    gwm_out_if.source o_out,
    gwm_cfg_if.sink   i_cfg
);
    import gwm_pkg::*;

    // Pattern length and overflow flag, set by append requests until the next clear request.
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_ovf;
    logic             n_ovf;
    logic             r_case;

    // Output register; it decouples the sink from the cell row.
    logic             r_out_valid;
    logic             r_matched;
    logic             r_out_ovf;

    // Active bit of the position just past a full store.
    logic             r_act_end;
    logic             n_act_end;

    logic             w_accept;
    logic             w_room;
    logic             w_hit;
    t_kind            w_kind;
    t_cell_ctl        w_ctl;

    // Step and closure signals ripple along the row: entry g feeds cell g.
    logic [MAX_PATTERN:0]   w_step;
    logic [MAX_PATTERN:0]   w_clos;
    logic [MAX_PATTERN:0]   w_act;

    assign i_cfg.ready = 1'b1;
    // A new request is taken whenever the output register is free or being drained.
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_kind      = t_kind'(i_in.kind);
    assign w_room      = r_len < LEN_W'(MAX_PATTERN);

    // Control for the row. A value byte advances the active set; every other
    // request restarts matching from the first position of the (new) pattern.
    always_comb begin
        w_ctl.update  = w_accept;
        w_ctl.advance = (w_kind == KIND_VALUE);
        w_ctl.fold_en = r_case;
        w_ctl.ch      = i_in.ch;
    end

    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        if (w_accept) begin
            case (w_kind)
                KIND_CLEAR: begin
                    n_len = '0;
                    n_ovf = 1'b0;
                end
                KIND_APPEND: begin
                    if (w_room) begin
                        n_len = r_len + LEN_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_step[0] = 1'b0;
    assign w_clos[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            logic w_wr_en;
            logic w_in_len;

            assign w_wr_en  = w_accept && (w_kind == KIND_APPEND) && w_room &&
                              (r_len == LEN_W'(g));
            assign w_in_len = n_len > LEN_W'(g);

            gwm_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_first    ((g == 0) ? 1'b1 : 1'b0),
                .i_ctl      (w_ctl),
                .i_wr_en    (w_wr_en),
                .i_in_len   (w_in_len),
                .i_step_in  (w_step[g]),
                .i_clos_in  (w_clos[g]),
                .o_step_out (w_step[g+1]),
                .o_clos_out (w_clos[g+1]),
                .o_act      (w_act[g])
            );
        end
    endgenerate

    // The position after the last cell can be reached but hands no step on.
    always_comb begin
        n_act_end = r_act_end;
        if (w_accept) begin
            n_act_end = (w_ctl.advance && w_step[MAX_PATTERN]) || w_clos[MAX_PATTERN];
        end
    end

    assign w_act[MAX_PATTERN] = r_act_end;
    // The whole value matched when the position at the pattern's end is active.
    assign w_hit = w_act[r_len];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_case      <= 1'b0;
            r_act_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_ovf     <= n_ovf;
            r_act_end <= n_act_end;
            if (i_cfg.valid && i_cfg.ready) begin
                r_case <= i_cfg.case_insensitive;
            end
            if (w_accept && (w_kind == KIND_END)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload is loaded with the verdict when an end request is taken.
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_kind == KIND_END)) begin
            r_matched <= w_hit && !r_ovf;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.matched          = r_matched;
    assign o_out.pattern_overflow = r_out_ovf;

endmodule

### sv/gwm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher position cell
// Holds one pattern byte and the active bit of its position, hands a step
// to the next position on a matching byte and passes the star closure on.
// ----------------------------------------------------------------------------
module gwm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_first,
    input  gwm_pkg::t_cell_ctl i_ctl,
    input  logic              i_wr_en,
    input  logic              i_in_len,
    input  logic              i_step_in,
    input  logic              i_clos_in,
    output logic              o_step_out,
    output logic              o_clos_out,
    output logic              o_act
);
    import gwm_pkg::*;

    logic [7:0] r_ch;
    logic [7:0] n_ch;
    logic       r_act;
    logic       n_act;
    logic       w_star_now;
    logic       w_star_next;
    logic       w_pre;

    always_comb begin
        n_ch        = i_wr_en ? i_ctl.ch : r_ch;
        w_star_now  = i_in_len && (r_ch == CH_STAR);
        w_star_next = i_in_len && (n_ch == CH_STAR);
        // A literal or '?' moves the position on by one byte.
        o_step_out  = i_in_len && r_act && !w_star_now &&
                      ((r_ch == CH_QMARK) ||
                       (fold(r_ch, i_ctl.fold_en) == fold(i_ctl.ch, i_ctl.fold_en)));
        w_pre       = i_ctl.advance ? ((r_act && w_star_now) || i_step_in) : i_first;
        n_act       = i_ctl.update ? (w_pre || i_clos_in) : r_act;
        o_clos_out  = n_act && w_star_next;
        o_act       = r_act;
    end

    always_ff @(posedge i_clk) begin
        r_ch <= n_ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= i_first;
        end else begin
            r_act <= n_act;
        end
    end

endmodule

### sv/gwm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob wildcard matcher port checker
// Watches the top level's ports and checks result ordering and flags.
// ----------------------------------------------------------------------------
module gwm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_kind,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_matched,
    input logic       i_pattern_overflow
);
    import gwm_pkg::*;

    logic w_end_acc;
    assign w_end_acc = i_in_valid && i_in_ready && (i_in_kind == KIND_END);

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_matched) && $stable(i_pattern_overflow))
        else $error("result changed while stalled");

    // An overflowed pattern never reports a match.
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_matched && i_pattern_overflow))
        else $error("match reported with overflow");

    // Every accepted end request gives a result in the next cycle.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_acc |=> i_out_valid)
        else $error("end request gave no result");

    // A fresh result appears only after an accepted end request.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_end_acc))
        else $error("result without end request");

endmodule

bind glob_wildcard_matcher_unit gwm_checker u_gwm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_in_kind          (i_in.kind),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_matched          (o_out.matched),
    .i_pattern_overflow (o_out.pattern_overflow)
);
